### sv/clpg_pkg.sv
// clpg_pkg: shared types and constants of the clipped line point generator.
// No dependencies; every other file takes its names from here by scope.
`timescale 1ns / 1ps

package clpg_pkg;

    localparam int unsigned COORD_BITS  = 12;
    localparam int unsigned ERR_BITS    = COORD_BITS + 1;
    localparam int unsigned COLOR_BITS  = 32;
    localparam int unsigned ADDR_BITS   = 22;
    localparam int unsigned CFG_BITS    = 12;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(640);
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(480);

    typedef enum logic {
        CMD_BEGIN   = 1'b0,
        CMD_ADVANCE = 1'b1
    } t_command;

    typedef enum logic {
        REG_CANVAS_WIDTH  = 1'b0,
        REG_CANVAS_HEIGHT = 1'b1
    } t_reg_index;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [COORD_BITS-1:0]        t_len;

    typedef struct packed {
        t_command              command;
        logic [COLOR_BITS-1:0] line_color;
        t_coord                start_x;
        t_coord                start_y;
        t_coord                end_x;
        t_coord                end_y;
    } t_in_item;

    typedef struct packed {
        logic                  point_valid;
        t_coord                point_x;
        t_coord                point_y;
        logic                  inside_canvas;
        logic [ADDR_BITS-1:0]  pixel_address;
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  last_point;
    } t_out_item;

    // decoded command between front and stepper
    typedef struct packed {
        t_command              command;
        logic [COLOR_BITS-1:0] color;
        t_coord                sx;
        t_coord                sy;
        t_coord                ex;
        t_coord                ey;
        t_len                  major_len;
        t_len                  minor_len;
        logic                  x_is_major;
        logic                  x_step_neg;
        logic                  y_step_neg;
        logic                  single_point;
    } t_line_cmd;

    // stepped point before clipping and addressing
    typedef struct packed {
        logic                  point_valid;
        t_coord                x;
        t_coord                y;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
    } t_step_point;

    typedef struct packed {
        logic [CFG_BITS-1:0] width;
        logic [CFG_BITS-1:0] height;
    } t_canvas_cfg;

endpackage

### sv/clpg_front.sv
// clpg_front: classifies an incoming command, working out distances, major axis
// and step directions of a new line. Depends on clpg_pkg.
`timescale 1ns / 1ps

module clpg_front (
    input  clpg_pkg::t_in_item  i_item,
    output clpg_pkg::t_line_cmd o_cmd
);

    logic signed [clpg_pkg::COORD_BITS:0] diff_x;
    logic signed [clpg_pkg::COORD_BITS:0] diff_y;
    clpg_pkg::t_len                       dist_x;
    clpg_pkg::t_len                       dist_y;
    logic                                 x_major;

    always_comb begin
        diff_x  = (clpg_pkg::COORD_BITS+1)'(i_item.end_x) -
                  (clpg_pkg::COORD_BITS+1)'(i_item.start_x);
        diff_y  = (clpg_pkg::COORD_BITS+1)'(i_item.end_y) -
                  (clpg_pkg::COORD_BITS+1)'(i_item.start_y);
        dist_x  = diff_x[clpg_pkg::COORD_BITS] ?
                  clpg_pkg::COORD_BITS'(-diff_x) : clpg_pkg::COORD_BITS'(diff_x);
        dist_y  = diff_y[clpg_pkg::COORD_BITS] ?
                  clpg_pkg::COORD_BITS'(-diff_y) : clpg_pkg::COORD_BITS'(diff_y);
        x_major = dist_x >= dist_y;

        o_cmd.command      = i_item.command;
        o_cmd.color        = i_item.line_color;
        o_cmd.sx           = i_item.start_x;
        o_cmd.sy           = i_item.start_y;
        o_cmd.ex           = i_item.end_x;
        o_cmd.ey           = i_item.end_y;
        o_cmd.x_is_major   = x_major;
        o_cmd.major_len    = x_major ? dist_x : dist_y;
        o_cmd.minor_len    = x_major ? dist_y : dist_x;
        o_cmd.x_step_neg   = i_item.start_x > i_item.end_x;
        o_cmd.y_step_neg   = i_item.start_y > i_item.end_y;
        o_cmd.single_point = (i_item.start_x == i_item.end_x) &&
                             (i_item.start_y == i_item.end_y);
    end

endmodule

### sv/clpg_queue.sv
// clpg_queue: short first-in first-out queue of decoded line commands
// between the front and the stepper. Depends on clpg_pkg.
`timescale 1ns / 1ps

module clpg_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  clpg_pkg::t_line_cmd i_cmd,
    output logic                o_full,
    input  logic                i_pop,
    output clpg_pkg::t_line_cmd o_cmd,
    output logic                o_empty
);

    clpg_pkg::t_line_cmd                r_mem [clpg_pkg::QUEUE_DEPTH];
    logic [clpg_pkg::QPTR_BITS-1:0]     r_wr_ptr;
    logic [clpg_pkg::QPTR_BITS-1:0]     r_rd_ptr;
    logic [clpg_pkg::QPTR_BITS:0]       r_count;
    logic [clpg_pkg::QPTR_BITS-1:0]     n_wr_ptr;
    logic [clpg_pkg::QPTR_BITS-1:0]     n_rd_ptr;
    logic [clpg_pkg::QPTR_BITS:0]       n_count;
    logic                               wr_en;
    logic                               rd_en;

    always_comb begin
        o_full   = r_count == (clpg_pkg::QPTR_BITS+1)'(clpg_pkg::QUEUE_DEPTH);
        o_empty  = r_count == '0;
        o_cmd    = r_mem[r_rd_ptr];
        wr_en    = i_push && !o_full;
        rd_en    = i_pop && !o_empty;
        n_wr_ptr = wr_en ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = rd_en ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### sv/clpg_stepper.sv
// clpg_stepper: line stepping state; consumes one decoded command per cycle
// if the point register can take it; registers the point. Depends on clpg_pkg.
`timescale 1ns / 1ps

module clpg_stepper (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    input  clpg_pkg::t_line_cmd   i_cmd,
    output logic                  o_q_pop,
    output logic                  o_pt_valid,
    output clpg_pkg::t_step_point o_pt,
    input  logic                  i_pt_ready
);

    logic                                 r_active;
    clpg_pkg::t_coord                     r_cur_x;
    clpg_pkg::t_coord                     r_cur_y;
    clpg_pkg::t_coord                     r_tgt_x;
    clpg_pkg::t_coord                     r_tgt_y;
    logic [clpg_pkg::ERR_BITS-1:0]        r_err;
    clpg_pkg::t_len                       r_major;
    clpg_pkg::t_len                       r_minor;
    logic                                 r_x_major;
    logic                                 r_x_neg;
    logic                                 r_y_neg;
    logic [clpg_pkg::COLOR_BITS-1:0]      r_color;
    logic                                 r_pt_valid;
    clpg_pkg::t_step_point                r_pt;

    logic                                 n_active;
    clpg_pkg::t_coord                     n_cur_x;
    clpg_pkg::t_coord                     n_cur_y;
    clpg_pkg::t_coord                     n_tgt_x;
    clpg_pkg::t_coord                     n_tgt_y;
    logic [clpg_pkg::ERR_BITS-1:0]        n_err;
    clpg_pkg::t_len                       n_major;
    clpg_pkg::t_len                       n_minor;
    logic                                 n_x_major;
    logic                                 n_x_neg;
    logic                                 n_y_neg;
    logic [clpg_pkg::COLOR_BITS-1:0]      n_color;
    logic                                 n_pt_valid;
    clpg_pkg::t_step_point                n_pt;

    logic                                 fire;
    logic [clpg_pkg::ERR_BITS-1:0]        err_sum;
    logic                                 minor_step;
    clpg_pkg::t_coord                     step_x;
    clpg_pkg::t_coord                     step_y;
    logic                                 last;

    always_comb begin
        fire       = !i_q_empty && (!r_pt_valid || i_pt_ready);
        o_q_pop    = fire;
        o_pt_valid = r_pt_valid;
        o_pt       = r_pt;

        n_active   = r_active;
        n_cur_x    = r_cur_x;
        n_cur_y    = r_cur_y;
        n_tgt_x    = r_tgt_x;
        n_tgt_y    = r_tgt_y;
        n_err      = r_err;
        n_major    = r_major;
        n_minor    = r_minor;
        n_x_major  = r_x_major;
        n_x_neg    = r_x_neg;
        n_y_neg    = r_y_neg;
        n_color    = r_color;
        n_pt       = r_pt;
        n_pt_valid = fire ? 1'b1 : (i_pt_ready ? 1'b0 : r_pt_valid);

        err_sum    = r_err + clpg_pkg::ERR_BITS'(r_minor);
        minor_step = err_sum >= clpg_pkg::ERR_BITS'(r_major);
        step_x     = r_cur_x;
        step_y     = r_cur_y;
        if (r_x_major || minor_step) begin
            step_x = r_x_neg ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
        end
        if (!r_x_major || minor_step) begin
            step_y = r_y_neg ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
        end
        last = r_x_major ? (step_x == r_tgt_x) : (step_y == r_tgt_y);

        if (fire) begin
            if (i_cmd.command == clpg_pkg::CMD_BEGIN) begin
                n_active        = !i_cmd.single_point;
                n_cur_x         = i_cmd.sx;
                n_cur_y         = i_cmd.sy;
                n_tgt_x         = i_cmd.ex;
                n_tgt_y         = i_cmd.ey;
                n_err           = '0;
                n_major         = i_cmd.major_len;
                n_minor         = i_cmd.minor_len;
                n_x_major       = i_cmd.x_is_major;
                n_x_neg         = i_cmd.x_step_neg;
                n_y_neg         = i_cmd.y_step_neg;
                n_color         = i_cmd.color;
                n_pt.point_valid = 1'b1;
                n_pt.x          = i_cmd.sx;
                n_pt.y          = i_cmd.sy;
                n_pt.color      = i_cmd.color;
                n_pt.last       = i_cmd.single_point;
            end else if (!r_active) begin
                n_pt            = '0;
            end else begin
                n_err           = minor_step ? err_sum - clpg_pkg::ERR_BITS'(r_major)
                                             : err_sum;
                n_cur_x         = last ? r_tgt_x : step_x;
                n_cur_y         = last ? r_tgt_y : step_y;
                n_active        = !last;
                n_pt.point_valid = 1'b1;
                n_pt.x          = last ? r_tgt_x : step_x;
                n_pt.y          = last ? r_tgt_y : step_y;
                n_pt.color      = r_color;
                n_pt.last       = last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_pt_valid <= 1'b0;
        end else begin
            r_active   <= n_active;
            r_pt_valid <= n_pt_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_x   <= n_cur_x;
        r_cur_y   <= n_cur_y;
        r_tgt_x   <= n_tgt_x;
        r_tgt_y   <= n_tgt_y;
        r_err     <= n_err;
        r_major   <= n_major;
        r_minor   <= n_minor;
        r_x_major <= n_x_major;
        r_x_neg   <= n_x_neg;
        r_y_neg   <= n_y_neg;
        r_color   <= n_color;
        r_pt      <= n_pt;
    end

endmodule

### sv/clpg_pixel.sv
// clpg_pixel: canvas registers, clip test and frame-buffer address of each point;
// holds the output register. Depends on clpg_pkg.
`timescale 1ns / 1ps

module clpg_pixel (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  clpg_pkg::t_reg_index          i_cfg_index,
    input  logic [clpg_pkg::CFG_BITS-1:0] i_cfg_data,
    input  logic                          i_pt_valid,
    input  clpg_pkg::t_step_point         i_pt,
    output logic                          o_pt_ready,
    output logic                          o_empty,
    output clpg_pkg::t_out_item           o_point,
    input  logic                          i_pop
);

    localparam int unsigned PROD_BITS = clpg_pkg::COORD_BITS + clpg_pkg::CFG_BITS;

    clpg_pkg::t_canvas_cfg             r_cfg;
    clpg_pkg::t_canvas_cfg             n_cfg;
    logic                              r_out_valid;
    logic                              n_out_valid;
    clpg_pkg::t_out_item               r_out;
    clpg_pkg::t_out_item               n_out;
    logic                              load;
    logic                              x_in;
    logic                              y_in;
    logic                              in_canvas;
    logic [PROD_BITS-1:0]              row_base;
    logic [PROD_BITS-1:0]              addr_full;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                clpg_pkg::REG_CANVAS_WIDTH:  n_cfg.width  = i_cfg_data;
                clpg_pkg::REG_CANVAS_HEIGHT: n_cfg.height = i_cfg_data;
                default:                     n_cfg        = r_cfg;
            endcase
        end
    end

    always_comb begin
        o_pt_ready  = !r_out_valid || i_pop;
        o_empty     = !r_out_valid;
        o_point     = r_out;
        load        = i_pt_valid && o_pt_ready;
        n_out_valid = load ? 1'b1 : (i_pop ? 1'b0 : r_out_valid);

        x_in      = !i_pt.x[clpg_pkg::COORD_BITS-1] &&
                    (clpg_pkg::COORD_BITS'(i_pt.x) < r_cfg.width);
        y_in      = !i_pt.y[clpg_pkg::COORD_BITS-1] &&
                    (clpg_pkg::COORD_BITS'(i_pt.y) < r_cfg.height);
        in_canvas = i_pt.point_valid && x_in && y_in;
        row_base  = PROD_BITS'(clpg_pkg::COORD_BITS'(i_pt.y)) * PROD_BITS'(r_cfg.width);
        addr_full = row_base + PROD_BITS'(clpg_pkg::COORD_BITS'(i_pt.x));

        n_out.point_valid   = i_pt.point_valid;
        n_out.point_x       = i_pt.x;
        n_out.point_y       = i_pt.y;
        n_out.inside_canvas = in_canvas;
        n_out.pixel_address = in_canvas ? addr_full[clpg_pkg::ADDR_BITS-1:0] : '0;
        n_out.pixel_color   = i_pt.color;
        n_out.last_point    = i_pt.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= clpg_pkg::WIDTH_RESET;
            r_cfg.height <= clpg_pkg::HEIGHT_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_cfg        <= n_cfg;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

endmodule

### sv/clipped_line_point_generator_unit.sv
// clipped_line_point_generator_unit: top level of the clipped line point generator.
// Depends on clpg_pkg, clpg_front, clpg_queue, clpg_stepper and clpg_pixel.
//
// Usage:
//   Commands enter through push/full: a transfer happens when push is high and
//   full is low. A begin command latches a line and yields its start point; each
//   advance yields the next point (an advance with no line open yields an
//   all-zero result with point_valid low). Exactly one result per command.
//   Results leave through empty/pop: the oldest result sits on o_point while
//   empty is low and is taken when pop is high.
//   A result passes the command queue, the stepper's point register and the output register.
//   Throughput: one command per cycle while pop keeps up, set by the stepper's single
//   add-compare-subtract per point; the clip/address stage runs in parallel.
//   A stalled pop fills the output register, the stepper's point register and
//   then the four-entry command queue, after which full rises; nothing is dropped.
//   Canvas width/height are written through i_cfg_* while idle; reset returns
//   them to 640 x 480 and empties every stage.
`timescale 1ns / 1ps

module clipped_line_point_generator_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  clpg_pkg::t_in_item            i_item,
    output logic                          empty,
    input  logic                          pop,
    output clpg_pkg::t_out_item           o_point,
    input  logic                          i_cfg_we,
    input  clpg_pkg::t_reg_index          i_cfg_index,
    input  logic [clpg_pkg::CFG_BITS-1:0] i_cfg_data
);

    clpg_pkg::t_line_cmd   front_cmd;
    clpg_pkg::t_line_cmd   q_cmd;
    logic                  q_empty;
    logic                  q_pop;
    logic                  pt_valid;
    logic                  pt_ready;
    clpg_pkg::t_step_point pt;

    clpg_front u_front (
        .i_item (i_item),
        .o_cmd  (front_cmd)
    );

    clpg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_empty (q_empty)
    );

    clpg_stepper u_stepper (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_cmd      (q_cmd),
        .o_q_pop    (q_pop),
        .o_pt_valid (pt_valid),
        .o_pt       (pt),
        .i_pt_ready (pt_ready)
    );

    clpg_pixel u_pixel (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pt_valid  (pt_valid),
        .i_pt        (pt),
        .o_pt_ready  (pt_ready),
        .o_empty     (empty),
        .o_point     (o_point),
        .i_pop       (pop)
    );

endmodule

### sim/tb_clipped_line_point_generator_unit.sv
// tb_clipped_line_point_generator_unit: self-checking regression of the line point generator.
// Depends on clpg_pkg and clipped_line_point_generator_unit; predicts every point in-bench,
// drives commands and pops results with random gaps across several canvas settings.
`timescale 1ns / 1ps

module tb_clipped_line_point_generator_unit;

    typedef struct {
        clpg_pkg::t_in_item item;
        bit                 settle;   // hold off until every pending point has been popped
    } t_feed_cmd;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          push = 1'b0;
    logic                          full;
    clpg_pkg::t_in_item            i_item = '0;
    logic                          empty;
    logic                          pop = 1'b0;
    clpg_pkg::t_out_item           o_point;
    logic                          i_cfg_we = 1'b0;
    clpg_pkg::t_reg_index          i_cfg_index = clpg_pkg::REG_CANVAS_WIDTH;
    logic [clpg_pkg::CFG_BITS-1:0] i_cfg_data = '0;

    clipped_line_point_generator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_point     (o_point),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // line stepper state mirrored in the bench
    bit          ln_active = 1'b0;
    int          pos_x = 0, pos_y = 0, tgt_x = 0, tgt_y = 0;
    int          acc = 0, major = 0, minor = 0;
    bit          x_major = 1'b0, x_neg = 1'b0, y_neg = 1'b0;
    logic [31:0] ln_color = '0;
    int          cfg_w = int'(clpg_pkg::WIDTH_RESET);
    int          cfg_h = int'(clpg_pkg::HEIGHT_RESET);

    t_feed_cmd           cmd_feed[$];
    clpg_pkg::t_out_item pending_points[$];

    int          fail_count = 0;
    int          n_lines = 0, n_points = 0, n_idle = 0, n_inside = 0, n_phases = 0;
    int          gen_w = 640, gen_h = 480;
    int          in_max_gap = 16, out_max_gap = 16;

    bit          in_taken = 1'b0, out_taken = 1'b0;
    bit          have_cmd = 1'b0;
    t_feed_cmd   cur_cmd;
    int          in_gap = 0, out_gap = 0;

    function automatic clpg_pkg::t_out_item step_line(clpg_pkg::t_in_item it);
        clpg_pkg::t_out_item r;
        int        sx, sy, ex, ey, dx, dy;
        bit        fin, mstep, in_canvas;
        int        addr;
        r = '0;
        if (it.command == clpg_pkg::CMD_BEGIN) begin
            sx = it.start_x;
            sy = it.start_y;
            ex = it.end_x;
            ey = it.end_y;
            dx = (ex >= sx) ? ex - sx : sx - ex;
            dy = (ey >= sy) ? ey - sy : sy - ey;
            fin = (sx == ex) && (sy == ey);
            ln_color = it.line_color;
            pos_x = sx;
            pos_y = sy;
            tgt_x = ex;
            tgt_y = ey;
            x_neg = sx > ex;
            y_neg = sy > ey;
            x_major = dx >= dy;
            major = x_major ? dx : dy;
            minor = x_major ? dy : dx;
            acc = 0;
            ln_active = !fin;
        end else if (ln_active) begin
            acc = acc + minor;
            mstep = acc >= major;
            if (mstep) begin
                acc = acc - major;
            end
            acc = acc & 32'h1FFF;
            if (x_major || mstep) begin
                pos_x = pos_x + (x_neg ? -1 : 1);
            end
            if (!x_major || mstep) begin
                pos_y = pos_y + (y_neg ? -1 : 1);
            end
            fin = x_major ? (pos_x == tgt_x) : (pos_y == tgt_y);
            if (fin) begin
                pos_x = tgt_x;
                pos_y = tgt_y;
                ln_active = 1'b0;
            end
        end else begin
            return r;
        end
        in_canvas = pos_x >= 0 && pos_x < cfg_w && pos_y >= 0 && pos_y < cfg_h;
        addr = in_canvas ? pos_x + pos_y * cfg_w : 0;
        r.point_valid   = 1'b1;
        r.point_x       = clpg_pkg::t_coord'(pos_x);
        r.point_y       = clpg_pkg::t_coord'(pos_y);
        r.inside_canvas = in_canvas;
        r.pixel_address = addr[clpg_pkg::ADDR_BITS-1:0];
        r.pixel_color   = ln_color;
        r.last_point    = fin;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a) begin
            $error("%s mismatch: expected %0h, got %0h", name, e, a);
            fail_count++;
        end
    endtask

    // monitor: config mirror, accepted commands, popped points
    always @(posedge i_clk) begin
        clpg_pkg::t_out_item e;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    clpg_pkg::REG_CANVAS_WIDTH:  cfg_w = int'(i_cfg_data);
                    clpg_pkg::REG_CANVAS_HEIGHT: cfg_h = int'(i_cfg_data);
                    default: ;
                endcase
            end
            if (push && !full) begin
                pending_points.push_back(step_line(i_item));
            end
            if (pop && !empty) begin
                if (pending_points.size() == 0) begin
                    $error("point popped with nothing pending: %0h", o_point);
                    fail_count++;
                end else begin
                    e = pending_points.pop_front();
                    check_field("point_valid", 32'(e.point_valid), 32'(o_point.point_valid));
                    check_field("point_x", 32'(e.point_x), 32'(o_point.point_x));
                    check_field("point_y", 32'(e.point_y), 32'(o_point.point_y));
                    check_field("inside_canvas", 32'(e.inside_canvas),
                                32'(o_point.inside_canvas));
                    check_field("pixel_address", 32'(e.pixel_address),
                                32'(o_point.pixel_address));
                    check_field("pixel_color", e.pixel_color, o_point.pixel_color);
                    check_field("last_point", 32'(e.last_point), 32'(o_point.last_point));
                    if (e.point_valid) begin
                        n_points++;
                    end else begin
                        n_idle++;
                    end
                    if (e.inside_canvas) begin
                        n_inside++;
                    end
                end
            end
        end
        in_taken  <= i_rst_n && push && !full;
        out_taken <= i_rst_n && pop && !empty;
    end

    // command driver
    always @(negedge i_clk) begin
        logic next_push;
        if (i_rst_n) begin
            next_push = push;
            if (push && in_taken) begin
                next_push = 1'b0;
                have_cmd = 1'b0;
            end
            if (!have_cmd && cmd_feed.size() > 0) begin
                cur_cmd = cmd_feed.pop_front();
                have_cmd = 1'b1;
                in_gap = $urandom_range(0, in_max_gap);
            end
            if (have_cmd && !next_push) begin
                if (cur_cmd.settle && pending_points.size() != 0) begin
                    next_push = 1'b0;
                end else if (in_gap > 0) begin
                    in_gap--;
                end else begin
                    next_push = 1'b1;
                    i_item <= cur_cmd.item;
                end
            end
            push <= next_push;
        end
    end

    // result consumer
    always @(negedge i_clk) begin
        logic next_pop;
        if (i_rst_n) begin
            next_pop = pop;
            if (pop && out_taken) begin
                next_pop = 1'b0;
                out_gap = $urandom_range(0, out_max_gap);
            end
            if (!next_pop) begin
                if (out_gap > 0) begin
                    out_gap--;
                end else begin
                    next_pop = 1'b1;
                end
            end
            pop <= next_pop;
        end
    end

    function automatic int clamp_coord(int v);
        if (v < -2048) return -2048;
        if (v > 2047) return 2047;
        return v;
    endfunction

    function automatic int rnd_full();
        return int'($urandom_range(0, 4095)) - 2048;
    endfunction

    function automatic int near_edge(int bound);
        case ($urandom_range(0, 3))
            0: return rnd_full();
            1: return int'($urandom_range(0, 20)) - 10;
            2: return clamp_coord(bound + int'($urandom_range(0, 20)) - 10);
            default: return clamp_coord(int'($urandom_range(0, bound)));
        endcase
    endfunction

    task automatic add_cmd(clpg_pkg::t_command c, int sx, int sy, int ex, int ey,
                           logic [31:0] col);
        t_feed_cmd lc;
        lc.item.command    = c;
        lc.item.line_color = col;
        lc.item.start_x    = clpg_pkg::t_coord'(sx);
        lc.item.start_y    = clpg_pkg::t_coord'(sy);
        lc.item.end_x      = clpg_pkg::t_coord'(ex);
        lc.item.end_y      = clpg_pkg::t_coord'(ey);
        // the fourth line always waits for a full drain; others do so at random
        lc.settle          = (c == clpg_pkg::CMD_BEGIN && n_lines == 3) ||
                             ($urandom_range(0, 199) == 0);
        if (c == clpg_pkg::CMD_BEGIN) begin
            n_lines++;
        end
        cmd_feed.push_back(lc);
    endtask

    task automatic add_advances(int n);
        repeat (n) begin
            add_cmd(clpg_pkg::CMD_ADVANCE, rnd_full(), rnd_full(), rnd_full(), rnd_full(),
                    $urandom);
        end
    endtask

    task automatic gen_random(int count);
        int n, sx, sy, ex, ey, span, steps, ax, ay;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 99) < 8) begin
                add_cmd(clpg_pkg::t_command'($urandom_range(0, 1)), rnd_full(), rnd_full(),
                        rnd_full(), rnd_full(), $urandom);
                n++;
            end else begin
                sx = near_edge(gen_w);
                sy = near_edge(gen_h);
                case ($urandom_range(0, 9))
                    0: span = 0;
                    1: span = 200;
                    default: span = 24;
                endcase
                if (span == 0) begin
                    ex = rnd_full();
                    ey = rnd_full();
                end else begin
                    ex = clamp_coord(sx + int'($urandom_range(0, 2 * span)) - span);
                    ey = clamp_coord(sy + int'($urandom_range(0, 2 * span)) - span);
                end
                ax = (ex >= sx) ? ex - sx : sx - ex;
                ay = (ey >= sy) ? ey - sy : sy - ey;
                steps = (ax >= ay) ? ax : ay;
                if (steps > 250) begin
                    steps = $urandom_range(10, 60);
                end
                case ($urandom_range(0, 9))
                    0: steps = $urandom_range(0, steps);
                    1: steps = steps + $urandom_range(1, 3);
                    default: ;
                endcase
                add_cmd(clpg_pkg::CMD_BEGIN, sx, sy, ex, ey, $urandom);
                add_advances(steps);
                n = n + 1 + steps;
            end
        end
    endtask

    task automatic drain_all();
        while (cmd_feed.size() != 0 || have_cmd || pending_points.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic set_canvas(int w, int h);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= clpg_pkg::REG_CANVAS_WIDTH;
        i_cfg_data  <= clpg_pkg::CFG_BITS'(w);
        @(negedge i_clk);
        i_cfg_index <= clpg_pkg::REG_CANVAS_HEIGHT;
        i_cfg_data  <= clpg_pkg::CFG_BITS'(h);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        gen_w = w;
        gen_h = h;
    endtask

    task automatic run_phase(int w, int h, int count, int gin, int gout);
        drain_all();
        repeat (4) @(negedge i_clk);
        set_canvas(w, h);
        in_max_gap  = gin;
        out_max_gap = gout;
        gen_random(count);
        n_phases++;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: default 640 x 480 canvas
        add_advances(1);
        add_cmd(clpg_pkg::CMD_BEGIN, 0, 0, 0, 0, 32'hFFFF_FFFF);
        add_advances(1);
        add_cmd(clpg_pkg::CMD_BEGIN, -2048, -2048, 2047, 2047, 32'h0000_0000);
        add_advances(2);
        add_cmd(clpg_pkg::CMD_BEGIN, 2047, -2048, -2048, 2047, 32'hA5A5_A5A5);
        add_advances(2);
        add_cmd(clpg_pkg::CMD_BEGIN, 637, 10, 641, 10, 32'h1234_5678);
        add_advances(4);
        add_cmd(clpg_pkg::CMD_BEGIN, 5, 481, 5, 478, 32'h5A5A_5A5A);
        add_advances(3);
        add_cmd(clpg_pkg::CMD_BEGIN, -1, -1, 1, 3, 32'h8000_0001);
        add_advances(4);
        gen_random(200);
        n_phases++;

        run_phase(1, 1, 150, 0, 16);
        run_phase(2048, 2048, 250, 16, 0);
        run_phase(4095, 4095, 250, 16, 16);
        run_phase(0, 0, 100, 0, 0);
        run_phase($urandom_range(1, 2048), $urandom_range(1, 2048), 300, 16, 16);
        run_phase(16, 12, 250, 8, 8);

        drain_all();
        repeat (8) @(negedge i_clk);
        $display("covered %0d phases, %0d lines begun, %0d points popped (%0d inside canvas),",
                 n_phases, n_lines, n_points, n_inside);
        $display("  %0d idle advances; %0d field mismatches", n_idle, fail_count);
        if (fail_count == 0) begin
            $display("clipped_line_point_generator_unit regression: pass");
        end else begin
            $display("clipped_line_point_generator_unit regression: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout waiting for the point stream");
        $display("clipped_line_point_generator_unit regression: fail");
        $finish;
    end

endmodule

### filelist.f
sv/clpg_pkg.sv
sv/clpg_front.sv
sv/clpg_queue.sv
sv/clpg_stepper.sv
sv/clpg_pixel.sv
sv/clipped_line_point_generator_unit.sv
sim/tb_clipped_line_point_generator_unit.sv
